@@ sv/fnsc_pkg.sv @@
// Shared types and constants for the frame number sequence corrector.
// No dependencies; used by fnsc_cell and the top level.
package fnsc_pkg;

   localparam int unsigned LOOKAHEAD_DEFAULT = 5;
   localparam int unsigned FN_W = 18;
   localparam int unsigned DIFF_W = FN_W + 2;
   localparam int CORR_LIMIT = 80000;

   localparam logic signed [FN_W-1:0] FN_ONE = FN_W'(1);
   localparam logic signed [FN_W-1:0] FN_MISSING = '1;
   localparam logic signed [FN_W-1:0] FN_CORR_MAX = FN_W'(CORR_LIMIT - 1);

   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_IS_PAL = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DISC_IS_CAV = CSR_IDX_W'(1);

   typedef struct packed {
      logic signed [FN_W-1:0] frame_number;
      logic                   is_last;
   } req_type;

   typedef struct packed {
      logic signed [FN_W-1:0] corrected_number;
      logic                   was_corrected;
      logic                   last_out;
   } rsp_type;

endpackage

@@ sv/fnsc_cell.sv @@
// One window cell: holds one raw frame number and checks it against the predecessor.
// Depends on fnsc_pkg.
module fnsc_cell #(
   parameter int unsigned INDEX = 0
) (
   input  logic                              clock,
   input  logic                              shift,
   input  logic                              load,
   input  logic                              gap_valid,
   input  logic signed [fnsc_pkg::FN_W-1:0]  load_number,
   input  logic signed [fnsc_pkg::FN_W-1:0]  next_number,
   input  logic signed [fnsc_pkg::FN_W-1:0]  prev_number,
   output logic signed [fnsc_pkg::FN_W-1:0]  number,
   output logic                              match
);

   logic signed [fnsc_pkg::FN_W-1:0]   number_ff;
   logic signed [fnsc_pkg::DIFF_W-1:0] diff;

   // Load a new request, else advance toward the head of the chain.
   always_ff @(posedge clock) begin
      if (load) begin
         number_ff <= load_number;
      end else if (shift) begin
         number_ff <= next_number;
      end
   end

   assign number = number_ff;
   assign diff   = fnsc_pkg::DIFF_W'(number_ff) - fnsc_pkg::DIFF_W'(prev_number);
   // Cell at gap k confirms the predecessor when it reads predecessor + k + 1.
   assign match  = gap_valid && (diff == fnsc_pkg::DIFF_W'(INDEX + 1));

endmodule

@@ sv/frame_number_sequence_corrector_unit.sv @@
// Top level of the frame number sequence corrector: cell chain, head logic, output stage.
// Depends on fnsc_pkg and fnsc_cell.
//
// The block repairs isolated bad or missing frame numbers in a stream of requests. Requests
// enter a chain of LOOKAHEAD cells that shifts toward the head; once the chain is full the
// head frame is emitted, so a result trails its request by LOOKAHEAD-1 requests. A head frame
// that is not its corrected predecessor plus one is renumbered to predecessor plus one when a
// later frame at gap g confirms it (reads predecessor + g + 1); a renumbered value outside
// 1..79999 becomes -1. The first frame of a sequence passes unchanged, and with an NTSC CAV
// setting missing numbers (below 1) pass unchanged. In steady state one request is taken and
// one result is given every cycle. While the result register holds a result that has not been
// taken nothing is emitted, so a full chain then holds req_ready low; a chain that is still
// filling keeps taking requests. A request marked last flushes the chain: the block then emits
// the remaining frames (up to LOOKAHEAD) one per cycle while rsp_ready is high and holds req_ready
// low until the final one is emitted, after which a new sequence starts. The rate is set by the
// single result register, one result per cycle while rsp_ready is high. Configuration writes
// take effect for every result emitted after them.
module frame_number_sequence_corrector_unit #(
   parameter int unsigned LOOKAHEAD = fnsc_pkg::LOOKAHEAD_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  fnsc_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output fnsc_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [fnsc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic                               csr_wdata
);

   localparam int unsigned FILL_W = $clog2(LOOKAHEAD + 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(LOOKAHEAD);
   localparam logic [FILL_W-1:0] FILL_ONE = FILL_W'(1);

   // Configuration registers.
   logic source_is_pal_ff;
   logic disc_is_cav_ff;

   // Sequence control.
   logic [FILL_W-1:0]                 fill_ff, fill_in;
   logic                              flush_ff, flush_in;
   logic                              have_prev_ff, have_prev_in;
   logic signed [fnsc_pkg::FN_W-1:0]  prev_ff, prev_in;

   // Result register.
   logic                              rsp_valid_ff;
   fnsc_pkg::rsp_type                 rsp_data_ff, rsp_data_in;

   logic                              accept;
   logic                              slot_free;
   logic                              emit;
   logic                              emit_last;
   logic [FILL_W-1:0]                 load_pos;
   logic signed [fnsc_pkg::FN_W-1:0]  cell_number [LOOKAHEAD];
   logic [LOOKAHEAD-1:0]              cell_match;
   logic signed [fnsc_pkg::FN_W-1:0]  head_number;
   logic                              ntsc_cav_missing;
   logic                              correct;
   logic                              in_range;
   logic signed [fnsc_pkg::FN_W-1:0]  out_number;

   // Handshake: the result register frees when empty or being taken.
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign emit      = slot_free && ((fill_ff == FILL_FULL) || (flush_ff && fill_ff != '0));
   assign emit_last = emit && flush_ff && (fill_ff == FILL_ONE);
   // Accept while filling, or when a full chain advances in this cycle; hold during a flush.
   assign req_ready = !flush_ff && ((fill_ff != FILL_FULL) || emit);
   assign accept    = req_valid && req_ready;

   // A new request lands behind the last valid cell, one place earlier when the chain advances.
   assign load_pos  = emit ? (fill_ff - FILL_ONE) : fill_ff;

   // Cell chain: cell 0 is the head, cell k is the frame at gap k.
   for (genvar k = 0; k < LOOKAHEAD; k++) begin : g_cell
      logic signed [fnsc_pkg::FN_W-1:0] next_number;
      if (k < LOOKAHEAD - 1) begin : g_mid
         assign next_number = cell_number[k+1];
      end else begin : g_tail
         assign next_number = req_data.frame_number;
      end

      fnsc_cell #(
         .INDEX(k)
      ) u_cell (
         .clock       (clock),
         .shift       (emit),
         .load        (accept && (load_pos == FILL_W'(k))),
         .gap_valid   (fill_ff > FILL_W'(k)),
         .load_number (req_data.frame_number),
         .next_number (next_number),
         .prev_number (prev_ff),
         .number      (cell_number[k]),
         .match       (cell_match[k])
      );
   end

   // Head logic. Cell 0's match means the head already follows its predecessor.
   assign head_number      = cell_number[0];
   assign ntsc_cav_missing = !source_is_pal_ff && disc_is_cav_ff && (head_number < fnsc_pkg::FN_ONE);
   assign correct          = have_prev_ff && !ntsc_cav_missing && !cell_match[0]
                             && (|cell_match[LOOKAHEAD-1:1]);
   // Predecessor + 1 lies in 1..79999 exactly when the predecessor lies in 0..79998.
   assign in_range         = !prev_ff[fnsc_pkg::FN_W-1] && (prev_ff < fnsc_pkg::FN_CORR_MAX);

   always_comb begin
      out_number = head_number;
      if (correct) begin
         out_number = in_range ? (prev_ff + fnsc_pkg::FN_ONE) : fnsc_pkg::FN_MISSING;
      end
      rsp_data_in.corrected_number = out_number;
      rsp_data_in.was_corrected    = correct;
      rsp_data_in.last_out         = emit_last;
   end

   // Next-state logic for the sequence control.
   always_comb begin
      fill_in      = fill_ff;
      flush_in     = flush_ff;
      have_prev_in = have_prev_ff;
      prev_in      = prev_ff;
      if (accept && !emit) begin
         fill_in = fill_ff + FILL_ONE;
      end else if (!accept && emit) begin
         fill_in = fill_ff - FILL_ONE;
      end
      if (accept && req_data.is_last) begin
         flush_in = 1'b1;
      end
      if (emit) begin
         have_prev_in = 1'b1;
         prev_in      = out_number;
      end
      // Drop the predecessor once the final frame leaves: the next request starts fresh.
      if (emit_last) begin
         flush_in     = 1'b0;
         have_prev_in = 1'b0;
         prev_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         flush_ff     <= 1'b0;
         have_prev_ff <= 1'b0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         flush_ff     <= flush_in;
         have_prev_ff <= have_prev_in;
         prev_ff      <= prev_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload: load on emit, hold otherwise.
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         source_is_pal_ff <= 1'b0;
         disc_is_cav_ff   <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            fnsc_pkg::CSR_SOURCE_IS_PAL: source_is_pal_ff <= csr_wdata;
            fnsc_pkg::CSR_DISC_IS_CAV:   disc_is_cav_ff   <= csr_wdata;
            default:                     ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The chain never holds more frames than it has cells.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_FULL)
      else $error("window fill count exceeds chain length");

   // No request enters while the chain is being flushed.
   a_flush_blocks: assert property (@(posedge clock) disable iff (reset)
      flush_ff |-> !req_ready)
      else $error("request ready during flush");

   // Emitting the final frame leaves an empty chain and a fresh sequence.
   a_flush_end: assert property (@(posedge clock) disable iff (reset)
      emit_last |=> (fill_ff == '0) && !flush_ff && !have_prev_ff)
      else $error("chain not cleared after final frame");

   // A renumbered frame is either in 1..79999 or marked -1.
   a_corr_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.was_corrected) |->
         ((rsp_data.corrected_number == fnsc_pkg::FN_MISSING) ||
          ((rsp_data.corrected_number >= fnsc_pkg::FN_ONE) &&
           (rsp_data.corrected_number <= fnsc_pkg::FN_CORR_MAX))))
      else $error("corrected frame number out of range");

endmodule
